// File: rtl/core/lrb_pkg.sv
// Package for the landmark range and bearing core: widths, pipeline types
// and the CORDIC arctangent table. No dependencies.
package lrb_pkg;

    localparam int CORDIC_STAGES = 18;
    localparam int ANGLE_BITS    = 16;
    localparam int POS_BITS      = 32;
    localparam int DIFF_BITS     = POS_BITS + 1;
    localparam int ROOT_BITS     = 34;
    localparam int REM_BITS      = 2 * ROOT_BITS;
    localparam int CXY_BITS      = DIFF_BITS + 3;
    localparam int BAM_BITS      = 16;
    localparam int ID_BITS       = 16;

    // atan(2^-i) at 2^32 units per turn.
    localparam logic [31:0] ATAN_TURN32 [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // One pipeline slot of the root and CORDIC section.
    typedef struct packed {
        logic [REM_BITS-1:0]        rem;
        logic [ROOT_BITS-1:0]       root;
        logic signed [CXY_BITS-1:0] x;
        logic signed [CXY_BITS-1:0] y;
        logic [ANGLE_BITS-1:0]      z;
        logic                       zero;
        logic [BAM_BITS-1:0]        heading;
        logic [ID_BITS-1:0]         id;
        logic                       last;
    } t_pipe;

    // Arctangent step rounded to the accumulator width.
    function automatic logic [ANGLE_BITS-1:0] atan_step(input int i);
        logic [31:0] t;
        t = ATAN_TURN32[i[4:0]] + (32'd1 << (31 - ANGLE_BITS));
        return t[31 -: ANGLE_BITS];
    endfunction

endpackage

// File: rtl/core/lrb_if.sv
// Valid/ready channel interfaces for the landmark range and bearing core.
// Depends on lrb_pkg.
interface lrb_in_if;
    import lrb_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [POS_BITS-1:0] robot_x;
    logic signed [POS_BITS-1:0] robot_y;
    logic [BAM_BITS-1:0]        robot_heading;
    logic signed [POS_BITS-1:0] landmark_x;
    logic signed [POS_BITS-1:0] landmark_y;
    logic [ID_BITS-1:0]         landmark_id;
    logic                       last_landmark;
    modport source (output valid, robot_x, robot_y, robot_heading, landmark_x,
                    landmark_y, landmark_id, last_landmark, input ready);
    modport sink (input valid, robot_x, robot_y, robot_heading, landmark_x,
                  landmark_y, landmark_id, last_landmark, output ready);
endinterface

interface lrb_out_if;
    import lrb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [ROOT_BITS-1:0] range_out;
    logic [BAM_BITS-1:0]  bearing_out;
    logic [ID_BITS-1:0]   signature_out;
    logic                 last_observation;
    modport source (output valid, range_out, bearing_out, signature_out,
                    last_observation, input ready);
    modport sink (input valid, range_out, bearing_out, signature_out,
                  last_observation, output ready);
endinterface

// File: rtl/core/landmark_range_bearing_core.sv
// Landmark range and bearing core: pipelined square root and CORDIC atan2.
// Depends on lrb_pkg and the channel interfaces in lrb_if.sv.
// Path: stage 1, stage 2, slot 0, ROOT_BITS root/CORDIC stages, output register.
// Throughput: one item per cycle; the whole pipeline stalls together
// while a result waits at the output register.
// Reset clears the valid bits of all stages; data registers are not reset.
module landmark_range_bearing_core (
    input logic    i_clk,
    input logic    i_rst_n,
    lrb_in_if.sink     i_in,
    lrb_out_if.source  o_out
);
    import lrb_pkg::*;

    logic en;

    // Stage 1: differences.
    logic                        r1_v;
    logic signed [DIFF_BITS-1:0] r1_dx, r1_dy;
    logic [BAM_BITS-1:0]         r1_head;
    logic [ID_BITS-1:0]          r1_id;
    logic                        r1_last;

    // Stage 2: squares and CORDIC pre-rotation.
    logic                        r2_v;
    logic [DIFF_BITS+31:0]       r2_sqx, r2_sqy;
    t_pipe                       r2_p;

    // Root/CORDIC section, slot 0 holds the sum of squares.
    logic  r_v  [0:ROOT_BITS];
    t_pipe r_p  [0:ROOT_BITS];
    t_pipe n_p  [1:ROOT_BITS];
    t_pipe n_p0;

    // Output register.
    logic                 r_o_v;
    logic [ROOT_BITS-1:0] r_o_range;
    logic [BAM_BITS-1:0]  r_o_bear;
    logic [ID_BITS-1:0]   r_o_id;
    logic                 r_o_last;

    assign en = !r_o_v || o_out.ready;
    assign i_in.ready = en;

    // Stage 1 register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
        end
        if (en) begin
            r1_dx   <= DIFF_BITS'(i_in.landmark_x) - DIFF_BITS'(i_in.robot_x);
            r1_dy   <= DIFF_BITS'(i_in.landmark_y) - DIFF_BITS'(i_in.robot_y);
            r1_head <= i_in.robot_heading;
            r1_id   <= i_in.landmark_id;
            r1_last <= i_in.last_landmark;
        end
    end

    // Stage 2: a magnitude of 2^32 has a zero low word, so one 32x32
    // multiplier per axis is enough.
    logic [DIFF_BITS-1:0] ax, ay;
    logic [63:0]          px, py;
    t_pipe                n2_p;

    always_comb begin
        ax = r1_dx[DIFF_BITS-1] ? DIFF_BITS'(-r1_dx) : DIFF_BITS'(r1_dx);
        ay = r1_dy[DIFF_BITS-1] ? DIFF_BITS'(-r1_dy) : DIFF_BITS'(r1_dy);
        px = ax[31:0] * ax[31:0];
        py = ay[31:0] * ay[31:0];
        n2_p = '0;
        if (r1_dx[DIFF_BITS-1]) begin
            n2_p.x = -CXY_BITS'(r1_dx);
            n2_p.y = -CXY_BITS'(r1_dy);
            n2_p.z = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
        end else begin
            n2_p.x = CXY_BITS'(r1_dx);
            n2_p.y = CXY_BITS'(r1_dy);
        end
        n2_p.zero    = (r1_dx == '0) && (r1_dy == '0);
        n2_p.heading = r1_head;
        n2_p.id      = r1_id;
        n2_p.last    = r1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_sqx <= ax[32] ? {1'b1, 64'd0} : {1'b0, px};
            r2_sqy <= ay[32] ? {1'b1, 64'd0} : {1'b0, py};
            r2_p   <= n2_p;
        end
    end

    // Stage 3: sum of squares seeds the root remainder.
    always_comb begin
        n_p0      = r2_p;
        n_p0.rem  = REM_BITS'(r2_sqx) + REM_BITS'(r2_sqy);
        n_p0.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= r2_v;
        end
        if (en) begin
            r_p[0] <= n_p0;
        end
    end

    // One root bit per stage; one CORDIC micro-rotation in each of the first CORDIC_STAGES stages.
    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        localparam int B = ROOT_BITS - 1 - k;
        logic [REM_BITS-1:0] trial;

        always_comb begin
            n_p[k+1] = r_p[k];
            trial = (REM_BITS'(r_p[k].root) << (B + 1)) + (REM_BITS'(1) << (2 * B));
            if (trial <= r_p[k].rem) begin
                n_p[k+1].rem  = r_p[k].rem - trial;
                n_p[k+1].root = r_p[k].root | (ROOT_BITS'(1) << B);
            end
            if (k < CORDIC_STAGES) begin
                if (r_p[k].y < 0) begin
                    n_p[k+1].x = r_p[k].x - (r_p[k].y >>> k);
                    n_p[k+1].y = r_p[k].y + (r_p[k].x >>> k);
                    n_p[k+1].z = r_p[k].z - atan_step(k);
                end else begin
                    n_p[k+1].x = r_p[k].x + (r_p[k].y >>> k);
                    n_p[k+1].y = r_p[k].y - (r_p[k].x >>> k);
                    n_p[k+1].z = r_p[k].z + atan_step(k);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (en) begin
                r_v[k+1] <= r_v[k];
            end
            if (en) begin
                r_p[k+1] <= n_p[k+1];
            end
        end
    end

    // Output stage: round the angle to 16 bits and subtract the heading.
    logic [ANGLE_BITS-1:0] z_fin;
    logic [32:0]           z_rnd;

    always_comb begin
        z_fin = r_p[ROOT_BITS].zero ? '0 : r_p[ROOT_BITS].z;
        z_rnd = (33'(z_fin) << (32 - ANGLE_BITS)) + 33'h8000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= r_v[ROOT_BITS];
        end
        if (en) begin
            r_o_range <= r_p[ROOT_BITS].root;
            r_o_bear  <= z_rnd[31:16] - r_p[ROOT_BITS].heading;
            r_o_id    <= r_p[ROOT_BITS].id;
            r_o_last  <= r_p[ROOT_BITS].last;
        end
    end

    assign o_out.valid            = r_o_v;
    assign o_out.range_out        = r_o_range;
    assign o_out.bearing_out      = r_o_bear;
    assign o_out.signature_out    = r_o_id;
    assign o_out.last_observation = r_o_last;

endmodule

// File: rtl/core/lrb_checker.sv
// Port-level checks for the landmark range and bearing core, with its bind.
// Depends on lrb_pkg and landmark_range_bearing_core.
module lrb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [lrb_pkg::ROOT_BITS-1:0] i_range,
    input logic [lrb_pkg::BAM_BITS-1:0]  i_bearing
);
    import lrb_pkg::*;

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result item valid right after reset");

    // A waiting result item holds its range and bearing.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_range)
        && $stable(i_bearing))
        else $error("stalled result item changed");

    // The pipeline takes an item whenever its output register can move.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

endmodule

bind landmark_range_bearing_core lrb_checker u_lrb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_range     (o_out.range_out),
    .i_bearing   (o_out.bearing_out)
);
